@@ rtl/polynomial_table_evaluator_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef POLYNOMIAL_TABLE_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_TABLE_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("polynomial table evaluator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("polynomial table evaluator: next-cycle check failed");

`endif

@@ rtl/pte_pkg.sv @@
`default_nettype none

package pte_pkg;

  localparam int HR_W       = 19;
  localparam int X_W        = HR_W + 1;
  localparam int ORD_W      = 3;
  localparam int COEF_W     = 32;
  localparam int Q_FRAC     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Accumulator widths after each Horner step; |x| < 8.0 adds four bits at the first step, three at each later one.
  localparam int ACC0_W = COEF_W;
  localparam int ACC1_W = COEF_W + 4;
  localparam int ACC2_W = COEF_W + 7;
  localparam int ACC3_W = COEF_W + 10;
  localparam int ACC4_W = COEF_W + 13;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [X_W-1:0]    x_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY_ORDER = 3'd0,
    CFG_HALF_RANGE = 3'd1,
    CFG_COEF_ZERO  = 3'd2,
    CFG_COEF_ONE   = 3'd3,
    CFG_COEF_TWO   = 3'd4,
    CFG_COEF_THREE = 3'd5,
    CFG_COEF_FOUR  = 3'd6
  } cfg_reg_t;

  localparam logic [ORD_W-1:0]  ORDER_RESET = 3'd0;
  localparam logic [HR_W-1:0]   RANGE_RESET = 19'd65536;
  localparam coef_t             ONE_Q16     = 32'sd65536;
  localparam coef_t             SAT_MAX     = 32'sh7fffffff;
  localparam coef_t             SAT_MIN     = 32'sh80000000;

endpackage

`default_nettype wire

@@ rtl/polynomial_table_evaluator.sv @@
// An accepted item passes the stages n, num, x2, p1, a1, p2, a2, p3, a3, p4, a4 and val.
// Throughput: one item per cycle; the twelve-stage pipeline moves as one whole and
// holds every stage while a waiting result is stalled.
// Reset (synchronous, active low) empties the pipeline and sets order 0, half range 1.0
// and coefficients 1.0, 0, 0, 0, 0, so every index then yields the constant 1.0.
`default_nettype none

module polynomial_table_evaluator #(
  parameter int TABLE_LENGTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [$clog2(TABLE_LENGTH):0]       in_table_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [pte_pkg::COEF_W-1:0]        out_poly_value,
  output logic                                     out_saturated,
  input  wire logic                                cfg_write_en,
  input  wire logic [pte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pte_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int LOG_W = $clog2(TABLE_LENGTH);
  localparam int IDX_W = LOG_W + 1;
  localparam int NUM_W = pte_pkg::HR_W + IDX_W;
  localparam int SCL_W = pte_pkg::HR_W + 2;
  localparam int P1_W  = pte_pkg::ACC0_W + pte_pkg::X_W;
  localparam int P2_W  = pte_pkg::ACC1_W + pte_pkg::X_W;
  localparam int P3_W  = pte_pkg::ACC2_W + pte_pkg::X_W;
  localparam int P4_W  = pte_pkg::ACC3_W + pte_pkg::X_W;
  localparam int NSTG  = 12;
  localparam logic [IDX_W-1:0] TL_IDX = IDX_W'(TABLE_LENGTH);

  logic [pte_pkg::ORD_W-1:0] order_r;
  logic [pte_pkg::HR_W-1:0]  half_range_r;
  pte_pkg::coef_t            coef_r [5];
  pte_pkg::coef_t            c1_m, c2_m, c3_m, c4_m;

  logic                      adv;
  logic [NSTG-1:0]           vld_r;

  logic [IDX_W-1:0]          n_r, n_nxt;
  logic [NUM_W-1:0]          num_r;
  logic [SCL_W-1:0]          scaled, x_wide;
  pte_pkg::x_t               x2_r, x3_r, x4_r, x5_r, x6_r, x7_r, x8_r;
  logic signed [pte_pkg::ACC0_W-1:0] a0_r;
  logic signed [P1_W-1:0]    p1_r;
  logic signed [pte_pkg::ACC1_W-1:0] a1_r, a1_nxt;
  logic signed [P2_W-1:0]    p2_r;
  logic signed [pte_pkg::ACC2_W-1:0] a2_r, a2_nxt;
  logic signed [P3_W-1:0]    p3_r;
  logic signed [pte_pkg::ACC3_W-1:0] a3_r, a3_nxt;
  logic signed [P4_W-1:0]    p4_r;
  logic signed [pte_pkg::ACC4_W-1:0] a4_r, a4_nxt;
  logic [pte_pkg::ACC4_W-pte_pkg::COEF_W:0] a4_top;
  logic                      sat_nxt;
  pte_pkg::coef_t            val_nxt;
  pte_pkg::coef_t            val_r;
  logic                      sat_r;

  function automatic int Q_FRAC_HI(input int acc_w);
    return pte_pkg::Q_FRAC + acc_w - 1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r      <= pte_pkg::ORDER_RESET;
      half_range_r <= pte_pkg::RANGE_RESET;
      coef_r[0]    <= pte_pkg::ONE_Q16;
      coef_r[1]    <= '0;
      coef_r[2]    <= '0;
      coef_r[3]    <= '0;
      coef_r[4]    <= '0;
    end else if (cfg_write_en) begin
      case (pte_pkg::cfg_reg_t'(cfg_index))
        pte_pkg::CFG_POLY_ORDER: order_r      <= cfg_data[pte_pkg::ORD_W-1:0];
        pte_pkg::CFG_HALF_RANGE: half_range_r <= cfg_data[pte_pkg::HR_W-1:0];
        pte_pkg::CFG_COEF_ZERO:  coef_r[0]    <= signed'(cfg_data);
        pte_pkg::CFG_COEF_ONE:   coef_r[1]    <= signed'(cfg_data);
        pte_pkg::CFG_COEF_TWO:   coef_r[2]    <= signed'(cfg_data);
        pte_pkg::CFG_COEF_THREE: coef_r[3]    <= signed'(cfg_data);
        pte_pkg::CFG_COEF_FOUR:  coef_r[4]    <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Coefficients above the order in use read as zero, so Horner always runs four steps.
  assign c1_m = (order_r >= 3'd1) ? coef_r[1] : '0;
  assign c2_m = (order_r >= 3'd2) ? coef_r[2] : '0;
  assign c3_m = (order_r >= 3'd3) ? coef_r[3] : '0;
  assign c4_m = (order_r >= 3'd4) ? coef_r[4] : '0;

  assign adv      = !(vld_r[NSTG-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_comb begin
    n_nxt  = (in_table_index > TL_IDX) ? TL_IDX : in_table_index;
    scaled = num_r[NUM_W-1:LOG_W-1];
    x_wide = scaled - {2'b00, half_range_r};
    a1_nxt = signed'(p1_r[Q_FRAC_HI(pte_pkg::ACC1_W):pte_pkg::Q_FRAC])
             + pte_pkg::ACC1_W'(c3_m);
    a2_nxt = signed'(p2_r[Q_FRAC_HI(pte_pkg::ACC2_W):pte_pkg::Q_FRAC])
             + pte_pkg::ACC2_W'(c2_m);
    a3_nxt = signed'(p3_r[Q_FRAC_HI(pte_pkg::ACC3_W):pte_pkg::Q_FRAC])
             + pte_pkg::ACC3_W'(c1_m);
    a4_nxt = signed'(p4_r[Q_FRAC_HI(pte_pkg::ACC4_W):pte_pkg::Q_FRAC])
             + pte_pkg::ACC4_W'(coef_r[0]);
    a4_top  = a4_r[pte_pkg::ACC4_W-1:pte_pkg::COEF_W-1];
    sat_nxt = !((&a4_top) || !(|a4_top));
    if (!sat_nxt) begin
      val_nxt = signed'(a4_r[pte_pkg::COEF_W-1:0]);
    end else if (a4_r[pte_pkg::ACC4_W-1]) begin
      val_nxt = pte_pkg::SAT_MIN;
    end else begin
      val_nxt = pte_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r   <= n_nxt;
      num_r <= NUM_W'(half_range_r) * NUM_W'(n_r);
      x2_r  <= signed'(x_wide[pte_pkg::X_W-1:0]);
      a0_r  <= c4_m;
      p1_r  <= P1_W'(a0_r) * P1_W'(x2_r);
      x3_r  <= x2_r;
      a1_r  <= a1_nxt;
      x4_r  <= x3_r;
      p2_r  <= P2_W'(a1_r) * P2_W'(x4_r);
      x5_r  <= x4_r;
      a2_r  <= a2_nxt;
      x6_r  <= x5_r;
      p3_r  <= P3_W'(a2_r) * P3_W'(x6_r);
      x7_r  <= x6_r;
      a3_r  <= a3_nxt;
      x8_r  <= x7_r;
      p4_r  <= P4_W'(a3_r) * P4_W'(x8_r);
      a4_r  <= a4_nxt;
      val_r <= val_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid      = vld_r[NSTG-1];
  assign out_poly_value = val_r;
  assign out_saturated  = sat_r;

endmodule

`default_nettype wire

@@ rtl/pte_checker.sv @@
`default_nettype none
`include "polynomial_table_evaluator_assert.svh"

module pte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_poly_value,
  input wire logic        out_saturated
);

  `PTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_poly_value) && $stable(out_saturated))
  `PTE_ASSERT_SAME(a_in_stall_cause, in_stall, out_valid && out_stall)
  `PTE_ASSERT_SAME(a_sat_limit, out_valid && out_saturated,
                   (out_poly_value == 32'h7fffffff) || (out_poly_value == 32'h80000000))

endmodule

bind polynomial_table_evaluator pte_checker u_pte_checker (.*);

`default_nettype wire
